@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top level of the witness check unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRW_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MRW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/mrw_pkg.sv @@
// Shared constants and types of the Miller-Rabin witness check unit.
package mrw_pkg;

  // Default width of the modulus and the base.
  localparam int MOD_BITS_DEFAULT = 31;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD,
    ST_SPLIT,
    ST_REDUCE,
    ST_POW_STEP,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_CHAIN_STEP,
    ST_CHAIN_SQR,
    ST_FINISH
  } state_t;

endpackage

@@ hw/rtl/mrw_modmul.sv @@
// Shift-and-add modular multiplier, one bit of the second operand per cycle.
module mrw_modmul import mrw_pkg::*; #(
  parameter int MOD_BITS = MOD_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [MOD_BITS-1:0] a,
  input  logic [MOD_BITS-1:0] b,
  input  logic [MOD_BITS-1:0] m,
  output logic                busy,
  output logic                done,
  output logic [MOD_BITS-1:0] prod
);

  localparam int CNT_W = $clog2(MOD_BITS);
  localparam int SUM_W = MOD_BITS + 2;

  logic [MOD_BITS-1:0] acc;
  logic [MOD_BITS-1:0] opa;
  logic [MOD_BITS-1:0] opb;
  logic [MOD_BITS-1:0] modv;
  logic [CNT_W-1:0]    cnt;

  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    mod1;
  logic [SUM_W-1:0]    mod2;
  logic [SUM_W-1:0]    red;

  // Double the accumulator, add the operand when the current bit is set, then
  // bring the sum, which stays below three times the modulus, back into range.
  always_comb begin
    sum  = {1'b0, acc, 1'b0} + (opb[MOD_BITS-1] ? {2'b00, opa} : {SUM_W{1'b0}});
    mod1 = {2'b00, modv};
    mod2 = {1'b0, modv, 1'b0};
    priority if (sum >= mod2) begin
      red = sum - mod2;
    end else if (sum >= mod1) begin
      red = sum - mod1;
    end else begin
      red = sum;
    end
  end

  // Control: bit counter, busy flag and the done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MOD_BITS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  // Operands and accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      opa  <= a;
      opb  <= b;
      modv <= m;
    end else if (busy) begin
      acc <= red[MOD_BITS-1:0];
      opb <= {opb[MOD_BITS-2:0], 1'b0};
    end
  end

  assign prod = acc;

endmodule

@@ hw/rtl/mrw_gcd.sv @@
// Binary gcd unit that tells whether two numbers are coprime.
module mrw_gcd import mrw_pkg::*; #(
  parameter int MOD_BITS = MOD_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [MOD_BITS-1:0] a,
  input  logic [MOD_BITS-1:0] b,
  output logic                done,
  output logic                coprime
);

  logic [MOD_BITS-1:0] ga;
  logic [MOD_BITS-1:0] gb;
  logic                busy;

  logic [MOD_BITS:0]   diff;
  logic                fin;
  logic                fin_coprime;

  // A zero second operand or a common factor of two ends the search early.
  // Otherwise halve even values and subtract the smaller odd value.
  always_comb begin
    diff        = {1'b0, ga} - {1'b0, gb};
    fin         = 1'b0;
    fin_coprime = 1'b0;
    priority if (gb == '0) begin
      fin         = 1'b1;
      fin_coprime = (ga == MOD_BITS'(1));
    end else if (!ga[0] && !gb[0]) begin
      fin = 1'b1;
    end else if (ga[0] && gb[0] && (ga == gb)) begin
      fin         = 1'b1;
      fin_coprime = (ga == MOD_BITS'(1));
    end
  end

  // Control: busy flag and the done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && fin) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Working values and the verdict.
  always_ff @(posedge clk) begin
    if (start) begin
      ga <= a;
      gb <= b;
    end else if (busy) begin
      priority if (fin) begin
        coprime <= fin_coprime;
      end else if (!ga[0]) begin
        ga <= {1'b0, ga[MOD_BITS-1:1]};
      end else if (!gb[0]) begin
        gb <= {1'b0, gb[MOD_BITS-1:1]};
      end else if (!diff[MOD_BITS]) begin
        ga <= diff[MOD_BITS-1:0];
      end else begin
        gb <= gb - ga;
      end
    end
  end

endmodule

@@ hw/rtl/miller_rabin_witness_check_unit.sv @@
// Top level of the Miller-Rabin witness check: sequencer around a shared multiplier.
//
// The request channel carries one transaction of a candidate modulus and a
// witness base; the response channel returns one transaction with the flag
// composite (1: the base proves the modulus composite, 0: probable prime).
// Both channels use valid and stall; a transaction moves when valid is high
// and stall is low.
// The unit works on one request at a time and holds req_stall high once the
// sequencer has left idle, until the verdict has been handed to the response
// register. The time per request is set mostly by the shared modular
// multiplier; a request needs at most about 2 * MOD_BITS products, plus a
// binary gcd and the split of the powers of two from N-1. A modulus below
// two is answered without any arithmetic.
// The response register lets a new request start while the previous verdict
// still waits; if the receiver stalls, the next verdict waits in the
// sequencer until the response register is free.
// A synchronous reset empties the response register and returns to idle.
`include "assert_macros.svh"

module miller_rabin_witness_check_unit import mrw_pkg::*; #(
  parameter int MOD_BITS = MOD_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [MOD_BITS-1:0] modulus,
  input  logic [MOD_BITS-1:0] base,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic                composite
);

  localparam int W_W = $clog2(MOD_BITS);

  state_t              state, state_next;
  logic [MOD_BITS-1:0] n, n_next;
  logic [MOD_BITS-1:0] y, y_next;
  logic [MOD_BITS-1:0] z, z_next;
  logic [W_W-1:0]      w, w_next;
  logic [MOD_BITS-1:0] x, x_next;
  logic [MOD_BITS-1:0] pbase, pbase_next;
  logic                verdict, verdict_next;
  logic                rsp_valid_next;
  logic                composite_next;
  logic                rsp_load;

  logic                mul_start;
  logic [MOD_BITS-1:0] mul_a;
  logic [MOD_BITS-1:0] mul_b;
  logic                mul_busy;
  logic                mul_done;
  logic [MOD_BITS-1:0] mul_prod;

  logic                gcd_start;
  logic                gcd_done;
  logic                gcd_coprime;

  // Shared modular multiplier; the modulus register is its modulus.
  mrw_modmul #(
    .MOD_BITS(MOD_BITS)
  ) u_modmul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .m    (n),
    .busy (mul_busy),
    .done (mul_done),
    .prod (mul_prod)
  );

  // Coprimality check, fed straight from the request ports.
  mrw_gcd #(
    .MOD_BITS(MOD_BITS)
  ) u_gcd (
    .clk    (clk),
    .rst    (rst),
    .start  (gcd_start),
    .a      (modulus),
    .b      (base),
    .done   (gcd_done),
    .coprime(gcd_coprime)
  );

  assign req_stall = (state != ST_IDLE);

  // Sequencer: next state, working values and multiplier requests.
  always_comb begin
    state_next   = state;
    n_next       = n;
    y_next       = y;
    z_next       = z;
    w_next       = w;
    x_next       = x;
    pbase_next   = pbase;
    verdict_next = verdict;
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    gcd_start    = 1'b0;
    rsp_load     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          n_next = modulus;
          y_next = base;
          if (modulus < MOD_BITS'(2)) begin
            verdict_next = 1'b1;
            state_next   = ST_FINISH;
          end else begin
            gcd_start  = 1'b1;
            state_next = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        if (gcd_done) begin
          if (!gcd_coprime) begin
            verdict_next = 1'b1;
            state_next   = ST_FINISH;
          end else begin
            z_next     = n - MOD_BITS'(1);
            w_next     = '0;
            state_next = ST_SPLIT;
          end
        end
      end
      ST_SPLIT: begin
        // Strip factors of two from N-1, then reduce the base modulo N.
        if (!z[0]) begin
          z_next = {1'b0, z[MOD_BITS-1:1]};
          w_next = w + W_W'(1);
        end else begin
          mul_start  = 1'b1;
          mul_a      = MOD_BITS'(1);
          mul_b      = y;
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mul_done) begin
          pbase_next = mul_prod;
          x_next     = MOD_BITS'(1);
          state_next = ST_POW_STEP;
        end
      end
      ST_POW_STEP: begin
        // Square and multiply, low exponent bit first.
        if (z == '0) begin
          if (x == MOD_BITS'(1)) begin
            verdict_next = 1'b0;
            state_next   = ST_FINISH;
          end else begin
            state_next = ST_CHAIN_STEP;
          end
        end else if (z[0]) begin
          mul_start  = 1'b1;
          mul_a      = x;
          mul_b      = pbase;
          state_next = ST_POW_MUL;
        end else begin
          mul_start  = 1'b1;
          mul_a      = pbase;
          mul_b      = pbase;
          state_next = ST_POW_SQR;
        end
      end
      ST_POW_MUL: begin
        if (mul_done) begin
          x_next     = mul_prod;
          z_next     = {z[MOD_BITS-1:1], 1'b0};
          state_next = ST_POW_STEP;
        end
      end
      ST_POW_SQR: begin
        if (mul_done) begin
          pbase_next = mul_prod;
          z_next     = {1'b0, z[MOD_BITS-1:1]};
          state_next = ST_POW_STEP;
        end
      end
      ST_CHAIN_STEP: begin
        // Look for N-1 among x and its successive squares, w values in all.
        if (w == '0) begin
          verdict_next = 1'b1;
          state_next   = ST_FINISH;
        end else if (x == n - MOD_BITS'(1)) begin
          verdict_next = 1'b0;
          state_next   = ST_FINISH;
        end else if (w == W_W'(1)) begin
          verdict_next = 1'b1;
          state_next   = ST_FINISH;
        end else begin
          mul_start  = 1'b1;
          mul_a      = x;
          mul_b      = x;
          w_next     = w - W_W'(1);
          state_next = ST_CHAIN_SQR;
        end
      end
      ST_CHAIN_SQR: begin
        if (mul_done) begin
          x_next     = mul_prod;
          state_next = ST_CHAIN_STEP;
        end
      end
      ST_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Response register: loaded from the verdict, emptied when taken.
  always_comb begin
    composite_next = rsp_load ? verdict : composite;
    priority if (rsp_load) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Working values and response payload.
  always_ff @(posedge clk) begin
    n         <= n_next;
    y         <= y_next;
    z         <= z_next;
    w         <= w_next;
    x         <= x_next;
    pbase     <= pbase_next;
    verdict   <= verdict_next;
    composite <= composite_next;
  end

  // The shared multiplier is never restarted while it is still working.
  `MRW_ASSERT_SAME(a_mul_no_restart, clk, rst, mul_start, !mul_busy, "multiplier restarted")

  // A product only arrives in a state that waits for one.
  `MRW_ASSERT_SAME(a_mul_done_state, clk, rst, mul_done, (state == ST_REDUCE || state == ST_POW_MUL || state == ST_POW_SQR || state == ST_CHAIN_SQR), "stray product")

  // The gcd result only arrives while the sequencer waits for it.
  `MRW_ASSERT_SAME(a_gcd_done_state, clk, rst, gcd_done, state == ST_GCD, "stray gcd result")

  // A modulus below two is reported composite without any arithmetic.
  `MRW_ASSERT_NEXT(a_small_modulus, clk, rst, req_valid && !req_stall && (modulus < MOD_BITS'(2)), state == ST_FINISH && verdict, "small modulus not composite")

endmodule
